@@ rtl/core/tcaa_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-channel converter averager package
// Shared constants for the averaging filters and the channel slot codes.
// ----------------------------------------------------------------------------
package tcaa_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int SPEED_ACC_W = 16;
    localparam int VOLT_ACC_W  = 12;
    localparam int LEVEL_W   = 10;
    localparam int CURRENT_W = 8;
    localparam int SLOT_W    = 2;

    localparam int SPEED_FILTER_LEN   = 64;
    localparam int VOLTAGE_FILTER_LEN = 4;
    localparam int SPEED_SHIFT   = $clog2(SPEED_FILTER_LEN);
    localparam int VOLTAGE_SHIFT = $clog2(VOLTAGE_FILTER_LEN);

    localparam logic [SAMPLE_W-1:0] SPEED_OFFSET = 10'd512;

    localparam logic [SLOT_W-1:0] SLOT_SPEED   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_VOLTAGE = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_CURRENT = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]     next_slot;
        logic [SLOT_W-1:0]     slot_updated;
        logic [CURRENT_W-1:0]  current_level;
        logic [LEVEL_W-1:0]    voltage_level;
        logic signed [LEVEL_W-1:0] speed_level;
    } result_t;

endpackage

@@ rtl/core/three_channel_adc_averager_core.sv @@
// ----------------------------------------------------------------------------
// Three-channel converter averager core
// Round-robin averaging of speed and voltage converter samples; current is held unfiltered.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload
//  s_       | in  | tdata[9:0] sample
//  m_       | out | tdata: speed, voltage, current, slot_updated, next_slot
//
// One item per cycle while the result side is not stalled; a sample is captured
// in an input register and its result is then loaded into the result register.
// Reset clears all accumulators, the current value and the slot (speed).
// A stalled result holds the result register and a full input register; input
// is accepted when the input register is empty or the result register can load.
// ----------------------------------------------------------------------------
module three_channel_adc_averager_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [9:0] speed_level, [19:10] voltage_level,
                                   // [27:20] current_level, [29:28] slot_updated,
                                   // [31:30] next_slot
);

    localparam int SPD_EXT_W = tcaa_pkg::SPEED_ACC_W + 2;
    localparam int VLT_EXT_W = tcaa_pkg::VOLT_ACC_W + 1;

    logic                                   in_valid_reg;
    logic [tcaa_pkg::SAMPLE_W-1:0]          sample_reg;
    logic                                   out_valid_reg;
    tcaa_pkg::result_t                      result_reg;
    tcaa_pkg::result_t                      result_next;

    logic signed [tcaa_pkg::SPEED_ACC_W-1:0] speed_acc_reg, speed_acc_next;
    logic [tcaa_pkg::VOLT_ACC_W-1:0]         volt_acc_reg, volt_acc_next;
    logic [tcaa_pkg::CURRENT_W-1:0]          current_reg, current_next;
    logic [tcaa_pkg::SLOT_W-1:0]             slot_index_reg, slot_index_next;

    logic                                    out_load;
    logic                                    work_en;

    logic signed [SPD_EXT_W-1:0]             spd_acc_ext;
    logic signed [SPD_EXT_W-1:0]             spd_quot;
    logic signed [SPD_EXT_W-1:0]             spd_x;
    logic signed [SPD_EXT_W-1:0]             spd_sum;
    logic [VLT_EXT_W-1:0]                    vlt_sum;
    logic signed [SPD_EXT_W-1:0]             lvl_ext;
    logic signed [SPD_EXT_W-1:0]             lvl_quot;
    logic [tcaa_pkg::VOLT_ACC_W-1:0]         vlt_quot;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign work_en  = in_valid_reg && out_load;

    // Signed division by a power of two, truncating toward zero.
    function automatic logic signed [SPD_EXT_W-1:0] div_trunc(
        input logic signed [SPD_EXT_W-1:0] v
    );
        logic signed [SPD_EXT_W-1:0] bias;
        bias = v[SPD_EXT_W-1] ? SPD_EXT_W'((1 << tcaa_pkg::SPEED_SHIFT) - 1)
                              : '0;
        return (v + bias) >>> tcaa_pkg::SPEED_SHIFT;
    endfunction

    always_comb begin
        spd_acc_ext = SPD_EXT_W'(speed_acc_reg);
        spd_quot    = div_trunc(spd_acc_ext);
        spd_x       = $signed({{(SPD_EXT_W-tcaa_pkg::SAMPLE_W){1'b0}}, sample_reg})
                    - $signed({{(SPD_EXT_W-tcaa_pkg::SAMPLE_W){1'b0}},
                               tcaa_pkg::SPEED_OFFSET});
        spd_sum     = spd_acc_ext - spd_quot + spd_x;
        vlt_sum     = VLT_EXT_W'(volt_acc_reg)
                    - VLT_EXT_W'(volt_acc_reg >> tcaa_pkg::VOLTAGE_SHIFT)
                    + VLT_EXT_W'(sample_reg);

        speed_acc_next  = speed_acc_reg;
        volt_acc_next   = volt_acc_reg;
        current_next    = current_reg;
        slot_index_next = tcaa_pkg::SLOT_SPEED;

        unique case (slot_index_reg)
            tcaa_pkg::SLOT_SPEED: begin
                if (spd_sum > SPD_EXT_W'(32767)) begin
                    speed_acc_next = 16'sh7FFF;
                end else if (spd_sum < -SPD_EXT_W'(32768)) begin
                    speed_acc_next = 16'sh8000;
                end else begin
                    speed_acc_next = spd_sum[tcaa_pkg::SPEED_ACC_W-1:0];
                end
                slot_index_next = tcaa_pkg::SLOT_VOLTAGE;
            end
            tcaa_pkg::SLOT_VOLTAGE: begin
                volt_acc_next = vlt_sum[VLT_EXT_W-1] ? '1
                              : vlt_sum[tcaa_pkg::VOLT_ACC_W-1:0];
                slot_index_next = tcaa_pkg::SLOT_CURRENT;
            end
            tcaa_pkg::SLOT_CURRENT: begin
                current_next    = sample_reg[tcaa_pkg::SAMPLE_W-1:2];
                slot_index_next = tcaa_pkg::SLOT_SPEED;
            end
            default: begin
                slot_index_next = tcaa_pkg::SLOT_SPEED;
            end
        endcase

        lvl_ext  = SPD_EXT_W'(speed_acc_next);
        lvl_quot = div_trunc(lvl_ext);
        vlt_quot = volt_acc_next >> tcaa_pkg::VOLTAGE_SHIFT;

        if (lvl_quot > SPD_EXT_W'(511)) begin
            result_next.speed_level = 10'sd511;
        end else if (lvl_quot < -SPD_EXT_W'(512)) begin
            result_next.speed_level = -10'sd512;
        end else begin
            result_next.speed_level = lvl_quot[tcaa_pkg::LEVEL_W-1:0];
        end
        result_next.voltage_level = (vlt_quot > tcaa_pkg::VOLT_ACC_W'(1023))
                                  ? '1 : vlt_quot[tcaa_pkg::LEVEL_W-1:0];
        result_next.current_level = current_next;
        result_next.slot_updated  = slot_index_reg;
        result_next.next_slot     = slot_index_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            speed_acc_reg  <= '0;
            volt_acc_reg   <= '0;
            current_reg    <= '0;
            slot_index_reg <= tcaa_pkg::SLOT_SPEED;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (work_en) begin
                speed_acc_reg  <= speed_acc_next;
                volt_acc_reg   <= volt_acc_next;
                current_reg    <= current_next;
                slot_index_reg <= slot_index_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            sample_reg <= s_tdata[tcaa_pkg::SAMPLE_W-1:0];
        end
        if (work_en) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    a_next_slot_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ((result_reg.slot_updated == tcaa_pkg::SLOT_SPEED
                && result_reg.next_slot == tcaa_pkg::SLOT_VOLTAGE)
          || (result_reg.slot_updated == tcaa_pkg::SLOT_VOLTAGE
                && result_reg.next_slot == tcaa_pkg::SLOT_CURRENT)
          || (result_reg.slot_updated == tcaa_pkg::SLOT_CURRENT
                && result_reg.next_slot == tcaa_pkg::SLOT_SPEED)))
        else $error("result slot sequence broken");

    a_slot_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        work_en |=> (result_reg.next_slot == slot_index_reg))
        else $error("reported next slot differs from slot state");

    a_current_only_in_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (current_reg != $past(current_reg) && $past(aresetn)) |->
            ($past(work_en) && $past(slot_index_reg) == tcaa_pkg::SLOT_CURRENT))
        else $error("current value changed outside its slot");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the three-channel converter averager core
// Feeds converter samples through the input stream, follows the speed and
// voltage averages and the current value in a local model, and compares every
// result item field by field against the model, with random stalls in some tests.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] sample, [15:10] zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [9:0] speed_level, [19:10] voltage_level,
                            // [27:20] current_level, [29:28] slot_updated,
                            // [31:30] next_slot

    three_channel_adc_averager_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcaa_pkg::result_t pending_levels[$];
    int          speed_sum;
    int          volt_sum;
    logic [7:0]  current_hold;
    logic [1:0]  slot_now;
    int          error_count;
    int          quiet_cycles;
    int          sent_count;
    logic        idle_on;
    logic        accepted;

    initial begin
        aclk = 1'b0;
    end

    always #6 aclk = ~aclk;

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
    end

    function automatic tcaa_pkg::result_t predict_levels(
        input logic [tcaa_pkg::SAMPLE_W-1:0] smp
    );
        tcaa_pkg::result_t res;
        logic [1:0] upd;
        logic [1:0] nxt;
        int         spd;
        int         vlt;
        upd = slot_now;
        if (upd == tcaa_pkg::SLOT_SPEED) begin
            spd = speed_sum - speed_sum / tcaa_pkg::SPEED_FILTER_LEN
                + (int'(smp) - 512);
            if (spd < -32768) spd = -32768;
            if (spd > 32767) spd = 32767;
            speed_sum = spd;
        end else if (upd == tcaa_pkg::SLOT_VOLTAGE) begin
            vlt = volt_sum - volt_sum / tcaa_pkg::VOLTAGE_FILTER_LEN + int'(smp);
            if (vlt > 4095) vlt = 4095;
            volt_sum = vlt;
        end else if (upd == tcaa_pkg::SLOT_CURRENT) begin
            current_hold = smp[9:2];
        end
        nxt = (upd == tcaa_pkg::SLOT_CURRENT || upd == tcaa_pkg::SLOT_UNUSED)
            ? tcaa_pkg::SLOT_SPEED : upd + 2'd1;
        slot_now = nxt;
        spd = speed_sum / tcaa_pkg::SPEED_FILTER_LEN;
        if (spd < -512) spd = -512;
        if (spd > 511) spd = 511;
        vlt = volt_sum / tcaa_pkg::VOLTAGE_FILTER_LEN;
        if (vlt > 1023) vlt = 1023;
        res.speed_level   = spd[tcaa_pkg::LEVEL_W-1:0];
        res.voltage_level = vlt[tcaa_pkg::LEVEL_W-1:0];
        res.current_level = current_hold;
        res.slot_updated  = upd;
        res.next_slot     = nxt;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_result(input tcaa_pkg::result_t got,
                                input tcaa_pkg::result_t want);
        if (got.speed_level !== want.speed_level)
            report_mismatch("speed_level", int'($signed(got.speed_level)),
                            int'($signed(want.speed_level)));
        if (got.voltage_level !== want.voltage_level)
            report_mismatch("voltage_level", int'(got.voltage_level),
                            int'(want.voltage_level));
        if (got.current_level !== want.current_level)
            report_mismatch("current_level", int'(got.current_level),
                            int'(want.current_level));
        if (got.slot_updated !== want.slot_updated)
            report_mismatch("slot_updated", int'(got.slot_updated),
                            int'(want.slot_updated));
        if (got.next_slot !== want.next_slot)
            report_mismatch("next_slot", int'(got.next_slot), int'(want.next_slot));
    endtask

    // Results are checked before new samples are predicted at the same edge.
    always @(posedge aclk) begin
        accepted = 1'b0;
        if (aresetn && m_tvalid && m_tready) begin
            accepted = 1'b1;
            if (pending_levels.size() == 0)
                report_mismatch("unexpected result item", 1, 0);
            else
                check_result(tcaa_pkg::result_t'(m_tdata), pending_levels.pop_front());
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted = 1'b1;
            pending_levels.push_back(predict_levels(s_tdata[tcaa_pkg::SAMPLE_W-1:0]));
        end
        quiet_cycles = accepted ? 0 : quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_sample(input logic [tcaa_pkg::SAMPLE_W-1:0] smp);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, smp};
        sent_count++;
        do
            @(posedge aclk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [tcaa_pkg::SAMPLE_W-1:0] trend_sample(input int mode);
        case (mode)
            0: return 10'd1023;
            1: return 10'd0;
            2: return 10'($urandom_range(960, 1023));
            3: return 10'($urandom_range(0, 63));
            4: return 10'($urandom_range(500, 524));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic [tcaa_pkg::SAMPLE_W-1:0] vals[$];
        vals = '{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023,
                 10'd512, 10'd511, 10'd3, 10'd511, 10'd512, 10'd4,
                 10'd513, 10'd1, 10'd1022, 10'h155, 10'h2AA, 10'h155,
                 10'h2AA, 10'h155, 10'h2AA};
        idle_on = 1'b0;
        foreach (vals[i])
            send_sample(vals[i]);
        wait_drained();
    endtask

    // Each channel follows its own level for a while, so the filters can settle
    // at full scale in either direction or at mid scale.
    task automatic test_filter_trends(input int blocks);
        int modes[3];
        idle_on = 1'b1;
        repeat (blocks) begin
            foreach (modes[c])
                modes[c] = $urandom_range(0, 5);
            repeat ($urandom_range(40, 120))
                send_sample(trend_sample(modes[sent_count % 3]));
        end
        wait_drained();
    endtask

    task automatic test_random_noise(input int count);
        idle_on = 1'b1;
        repeat (count)
            send_sample(10'($urandom_range(0, 1023)));
        wait_drained();
    endtask

    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        repeat (count)
            send_sample(10'($urandom));
    endtask

    initial begin
        speed_sum    = 0;
        volt_sum     = 0;
        current_hold = '0;
        slot_now     = tcaa_pkg::SLOT_SPEED;
        error_count  = 0;
        sent_count   = 0;
        idle_on      = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_filter_trends(7);
        test_random_noise(180);
        test_steady_stream(60);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (pending_levels.size() != 0)
            report_mismatch("results still outstanding", 0, pending_levels.size());
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
